// ===== sv/abs_pkg.sv =====
// abs_pkg: shared constants, types and helpers of the averaging background subtractor
// no dependencies; used by every other file of the block
`default_nettype none
package abs_pkg;

  localparam int PIXELS     = 65536;
  localparam int MAX_FRAMES = 256;

  localparam int IDX_W = 16;
  localparam int PIX_W = 8;
  localparam int SUM_W = 16;
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int N_W    = $clog2(MAX_FRAMES + 1);
  localparam int DN_W   = ((SUM_W > N_W) ? SUM_W : N_W) + 1;
  localparam int XN_W   = PIX_W + N_W;
  localparam int PR_W   = PIX_W + DN_W;
  localparam int CMP_W  = PR_W + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SCALE  = 1'd1;
  localparam logic [PIX_W-1:0] HIGH_SCALE_RST = 8'd20;
  localparam logic [PIX_W-1:0] LOW_SCALE_RST  = 8'd28;

  typedef enum logic {
    OP_LEARN    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic                       in_range;
    logic                       eof;
    logic [IDX_W-1:0]           idx;
    logic [2:0][PIX_W-1:0]      px;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/abs_in_if.sv =====
// abs_in_if: input pixel channel, valid/ready with payload
// depends on abs_pkg
`default_nettype none
interface abs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [abs_pkg::IDX_W-1:0]          pixel_index;
  logic [abs_pkg::PIX_W-1:0]          chan0;
  logic [abs_pkg::PIX_W-1:0]          chan1;
  logic [abs_pkg::PIX_W-1:0]          chan2;
  logic                               end_of_frame;

  modport source (output valid, operation, pixel_index, chan0, chan1, chan2, end_of_frame,
                  input ready);
  modport sink (input valid, operation, pixel_index, chan0, chan1, chan2, end_of_frame,
                output ready);
endinterface
`default_nettype wire

// ===== sv/abs_out_if.sv =====
// abs_out_if: result channel, valid/ready with index and foreground bit
// depends on abs_pkg
`default_nettype none
interface abs_out_if;
  logic                      valid;
  logic                      ready;
  logic [abs_pkg::IDX_W-1:0] out_index;
  logic                      foreground;

  modport source (output valid, out_index, foreground, input ready);
  modport sink (input valid, out_index, foreground, output ready);
endinterface
`default_nettype wire

// ===== sv/abs_front.sv =====
// abs_front: accepts pixel transactions and classifies them into queue items
// depends on abs_pkg, abs_in_if
`default_nettype none
module abs_front (
  abs_in_if.sink               in_chan,
  input  abs_pkg::back_stat_t  stat,
  input  logic                 q_full,
  output logic                 q_push,
  output abs_pkg::item_t       q_item
);

  assign in_chan.ready = !q_full && !stat.clearing;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    q_item.op       = in_chan.operation ? abs_pkg::OP_CLASSIFY : abs_pkg::OP_LEARN;
    q_item.in_range = (32'(in_chan.pixel_index) < 32'(abs_pkg::PIXELS));
    q_item.eof      = in_chan.end_of_frame;
    q_item.idx      = in_chan.pixel_index;
    q_item.px       = {in_chan.chan2, in_chan.chan1, in_chan.chan0};
  end

endmodule
`default_nettype wire

// ===== sv/abs_queue.sv =====
// abs_queue: short item queue between front and back
// depends on abs_pkg
`default_nettype none
module abs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  abs_pkg::item_t  push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output abs_pkg::item_t  head
);

  abs_pkg::item_t              mem_r [abs_pkg::Q_DEPTH];
  logic [abs_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [abs_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [abs_pkg::Q_CW-1:0]    cnt_r;

  assign full      = (cnt_r == abs_pkg::Q_CW'(abs_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == abs_pkg::Q_AW'(abs_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == abs_pkg::Q_AW'(abs_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + abs_pkg::Q_CW'(push) - abs_pkg::Q_CW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/abs_back.sv =====
// abs_back: model memories, read-modify-write learn path, classify compare, result queue
// depends on abs_pkg, abs_out_if
`default_nettype none
module abs_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  abs_pkg::item_t                     q_item,
  output logic                               q_pop,
  input  logic                               cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output abs_pkg::back_stat_t                stat,
  abs_out_if.source                          out_chan
);

  typedef logic [2:0][abs_pkg::SUM_W-1:0] sums_t;
  typedef logic [2:0][abs_pkg::PIX_W-1:0] pix_t;

  sums_t vs_mem [abs_pkg::PIXELS];
  sums_t ds_mem [abs_pkg::PIXELS];
  pix_t  pp_mem [abs_pkg::PIXELS];

  logic [abs_pkg::PIX_W-1:0]  high_r, low_r;
  logic                       clearing_r;
  logic [abs_pkg::PIX_AW-1:0] clr_cnt_r;
  logic [abs_pkg::N_W-1:0]    n_r;
  logic                       first_r;

  // stage 1: memory data arrives
  logic                       s1_v_r;
  abs_pkg::item_t             s1_item_r;
  sums_t                      vs_rd_r, ds_rd_r;
  pix_t                       pp_rd_r;
  // forwarding of last write
  logic                       fw_v_r;
  logic [abs_pkg::PIX_AW-1:0] fw_addr_r;
  sums_t                      fw_vs_r, fw_ds_r;
  pix_t                       fw_pp_r;

  // stage 2: products registered
  logic                            s2_v_r;
  logic [abs_pkg::IDX_W-1:0]       s2_idx_r;
  logic                            s2_zero_r;
  pix_t                            s2_px_r;
  sums_t                           s2_s_r;
  logic [2:0][abs_pkg::XN_W-1:0]   s2_xn_r;
  logic [2:0][abs_pkg::PR_W-1:0]   s2_lo_r, s2_hi_r;

  // result queue
  logic [abs_pkg::IDX_W-1:0]  oq_idx_r [abs_pkg::OQ_DEPTH];
  logic                       oq_fg_r  [abs_pkg::OQ_DEPTH];
  logic [abs_pkg::OQ_AW-1:0]  oq_wr_r, oq_rd_r;
  logic [abs_pkg::OQ_CW-1:0]  oq_cnt_r;

  logic [abs_pkg::PIX_AW-1:0] rd_addr, s1_addr, wr_addr;
  logic [abs_pkg::OQ_CW+1:0]  in_flight;
  logic                       issue, s1_fwd, learn_act, store, mem_we;
  sums_t                      vs_old, ds_old, vs_new, ds_new, vs_wd, ds_wd;
  pix_t                       pp_old;
  logic [abs_pkg::N_W-1:0]    nn;
  logic [2:0][abs_pkg::DN_W-1:0] dn;
  logic                       bg, oq_push, oq_pop;
  logic [2:0][abs_pkg::PIX_W-1:0] diff;

  assign stat.clearing = clearing_r;
  assign stat.busy     = s1_v_r || s2_v_r || (oq_cnt_r != '0);

  assign in_flight = (abs_pkg::OQ_CW+2)'(oq_cnt_r) + (abs_pkg::OQ_CW+2)'(s1_v_r)
                   + (abs_pkg::OQ_CW+2)'(s2_v_r);
  assign issue   = !clearing_r && q_valid
                && (in_flight < (abs_pkg::OQ_CW+2)'(abs_pkg::OQ_DEPTH));
  assign q_pop   = issue;
  assign rd_addr = q_item.idx[abs_pkg::PIX_AW-1:0];
  assign s1_addr = s1_item_r.idx[abs_pkg::PIX_AW-1:0];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= abs_pkg::HIGH_SCALE_RST;
      low_r  <= abs_pkg::LOW_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        abs_pkg::CFG_HIGH_SCALE: high_r <= cfg_data;
        abs_pkg::CFG_LOW_SCALE:  low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 combinational
  always_comb begin
    s1_fwd    = fw_v_r && (fw_addr_r == s1_addr);
    vs_old    = s1_fwd ? fw_vs_r : vs_rd_r;
    ds_old    = s1_fwd ? fw_ds_r : ds_rd_r;
    pp_old    = s1_fwd ? fw_pp_r : pp_rd_r;
    learn_act = s1_v_r && (s1_item_r.op == abs_pkg::OP_LEARN)
             && (n_r < abs_pkg::N_W'(abs_pkg::MAX_FRAMES));
    store     = learn_act && s1_item_r.in_range;
    for (int c = 0; c < 3; c++) begin
      diff[c]   = (s1_item_r.px[c] > pp_old[c]) ? s1_item_r.px[c] - pp_old[c]
                                                : pp_old[c] - s1_item_r.px[c];
      vs_new[c] = first_r ? vs_old[c] : abs_pkg::sat_add(vs_old[c], s1_item_r.px[c]);
      ds_new[c] = first_r ? ds_old[c] : abs_pkg::sat_add(ds_old[c], diff[c]);
    end
    mem_we  = clearing_r || store;
    wr_addr = clearing_r ? clr_cnt_r : s1_addr;
    vs_wd   = clearing_r ? '0 : vs_new;
    ds_wd   = clearing_r ? '0 : ds_new;
    nn      = s1_item_r.in_range ? n_r : '0;
    for (int c = 0; c < 3; c++) begin
      dn[c] = (s1_item_r.in_range ? abs_pkg::DN_W'(vs_old[c] & '0) + abs_pkg::DN_W'(ds_old[c])
                                  : '0) + abs_pkg::DN_W'(nn);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (issue) begin
      vs_rd_r <= vs_mem[rd_addr];
      ds_rd_r <= ds_mem[rd_addr];
      pp_rd_r <= pp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vs_mem[wr_addr] <= vs_wd;
      ds_mem[wr_addr] <= ds_wd;
    end
    if (store) begin
      pp_mem[s1_addr] <= s1_item_r.px;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      n_r        <= '0;
      first_r    <= 1'b1;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      fw_v_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == abs_pkg::PIX_AW'(abs_pkg::PIXELS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (learn_act && s1_item_r.eof) begin
        if (!first_r) begin
          n_r <= n_r + 1'b1;
        end
        first_r <= 1'b0;
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r && (s1_item_r.op == abs_pkg::OP_CLASSIFY);
      fw_v_r <= store;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r <= q_item;
    end
    fw_addr_r <= s1_addr;
    fw_vs_r   <= vs_new;
    fw_ds_r   <= ds_new;
    fw_pp_r   <= s1_item_r.px;
    s2_idx_r  <= s1_item_r.idx;
    s2_zero_r <= (nn == '0);
    s2_px_r   <= s1_item_r.px;
    for (int c = 0; c < 3; c++) begin
      s2_s_r[c]  <= s1_item_r.in_range ? vs_old[c] : '0;
      s2_xn_r[c] <= abs_pkg::XN_W'(s1_item_r.px[c]) * abs_pkg::XN_W'(nn);
      s2_lo_r[c] <= abs_pkg::PR_W'(low_r) * abs_pkg::PR_W'(dn[c]);
      s2_hi_r[c] <= abs_pkg::PR_W'(high_r) * abs_pkg::PR_W'(dn[c]);
    end
  end

  // stage 2 compare
  always_comb begin
    bg = 1'b1;
    for (int c = 0; c < 3; c++) begin
      if (s2_zero_r) begin
        if (s2_px_r[c] > high_r) bg = 1'b0;
      end else begin
        if (abs_pkg::CMP_W'(s2_xn_r[c]) + abs_pkg::CMP_W'(s2_lo_r[c])
            < abs_pkg::CMP_W'(s2_s_r[c])) bg = 1'b0;
        if (abs_pkg::CMP_W'(s2_xn_r[c])
            > abs_pkg::CMP_W'(s2_s_r[c]) + abs_pkg::CMP_W'(s2_hi_r[c])) bg = 1'b0;
      end
    end
  end

  // result queue
  assign oq_push            = s2_v_r;
  assign out_chan.valid      = (oq_cnt_r != '0);
  assign out_chan.out_index  = oq_idx_r[oq_rd_r];
  assign out_chan.foreground = oq_fg_r[oq_rd_r];
  assign oq_pop             = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_idx_r[oq_wr_r] <= s2_idx_r;
      oq_fg_r[oq_wr_r]  <= !bg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= (oq_wr_r == abs_pkg::OQ_AW'(abs_pkg::OQ_DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == abs_pkg::OQ_AW'(abs_pkg::OQ_DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + abs_pkg::OQ_CW'(oq_push) - abs_pkg::OQ_CW'(oq_pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/average_background_subtractor_core.sv =====
// average_background_subtractor_core: per-pixel averaging background model, top level
// path: a classify transaction passes the item queue, ram read, product registers and result queue
// throughput: one transaction per cycle while the result queue has room, via ram read-modify-write
// reset: synchronous active-low; afterwards a clearing pass over every pixel zeroes the sum rams,
// during which in_chan.ready stays low; configuration writes are taken at any time
// depends on abs_pkg, abs_in_if, abs_out_if, abs_front, abs_queue, abs_back
`default_nettype none
module average_background_subtractor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  abs_in_if.sink                             in_chan,
  abs_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // front to queue
  logic                 q_push;
  abs_pkg::item_t       q_in_item;
  logic                 q_full;
  // queue to back
  logic                 q_pop;
  logic                 q_not_empty;
  abs_pkg::item_t       q_head;
  // back status, gates the front during the clearing pass
  abs_pkg::back_stat_t  stat;

  // front: handshake and item classification (learn/classify, index range)
  abs_front u_front (
    .in_chan (in_chan),
    .stat    (stat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  // short queue so front and back stall independently
  abs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: ram read, update with forwarding, classify products, compare, result queue
  abs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for average_background_subtractor_core
// depends on abs_pkg, abs_in_if, abs_out_if and the core; predicts every classify result
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [2:0][abs_pkg::SUM_W-1:0] chan_sums_t;
  typedef logic [2:0][abs_pkg::PIX_W-1:0] chan_pix_t;

  typedef struct {
    abs_pkg::op_t              op;
    logic [abs_pkg::IDX_W-1:0] idx;
    chan_pix_t                 px;
    logic                      eof;
  } pixel_txn_t;

  typedef struct {
    logic [abs_pkg::IDX_W-1:0] idx;
    logic                      fg;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [abs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [abs_pkg::CFG_DATA_W-1:0] cfg_data;

  abs_in_if in_chan ();
  abs_out_if out_chan ();

  average_background_subtractor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock, period 4 ns
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // model state kept by the predictor
  chan_sums_t                value_acc [int];
  chan_sums_t                dev_acc [int];
  chan_pix_t                 last_px [int];
  int unsigned               frames_seen;
  logic                      in_first_frame;
  logic [abs_pkg::PIX_W-1:0] upper_mult;
  logic [abs_pkg::PIX_W-1:0] lower_mult;

  pixel_txn_t pending_pixels[$];
  verdict_t   expected_verdicts[$];
  int         error_count;
  bit         no_idle;

  // ---- predictor ----

  function automatic logic [abs_pkg::SUM_W-1:0] sum_clip(logic [abs_pkg::SUM_W-1:0] a,
                                                         int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 65535) ? 16'hffff : s[abs_pkg::SUM_W-1:0];
  endfunction

  function automatic bit channel_in_band(int unsigned x, int unsigned n, int unsigned s,
                                         int unsigned d);
    longint unsigned xn, dn;
    if (n == 0) return x <= upper_mult;
    xn = longint'(x) * n;
    dn = longint'(d) + n;
    if (xn + longint'(lower_mult) * dn < s) return 0;
    if (xn > s + longint'(upper_mult) * dn) return 0;
    return 1;
  endfunction

  // applies one accepted transaction to the model, queues a verdict for classify
  function automatic void absorb_pixel(pixel_txn_t t);
    chan_sums_t vs, ds;
    chan_pix_t  pv;
    int unsigned diff;
    bit bg;
    verdict_t v;
    int key;
    key = t.idx;
    vs = value_acc.exists(key) ? value_acc[key] : '0;
    ds = dev_acc.exists(key) ? dev_acc[key] : '0;
    pv = last_px.exists(key) ? last_px[key] : '0;
    if (t.op == abs_pkg::OP_LEARN) begin
      if (frames_seen >= abs_pkg::MAX_FRAMES) return;
      for (int c = 0; c < 3; c++) begin
        if (!in_first_frame) begin
          diff = (t.px[c] > pv[c]) ? t.px[c] - pv[c] : pv[c] - t.px[c];
          vs[c] = sum_clip(vs[c], t.px[c]);
          ds[c] = sum_clip(ds[c], diff);
        end
      end
      value_acc[key] = vs;
      dev_acc[key] = ds;
      last_px[key] = t.px;
      if (t.eof) begin
        if (!in_first_frame) frames_seen++;
        in_first_frame = 0;
      end
    end else begin
      bg = 1;
      for (int c = 0; c < 3; c++)
        if (!channel_in_band(t.px[c], frames_seen, vs[c], ds[c])) bg = 0;
      v.idx = t.idx;
      v.fg = !bg;
      expected_verdicts.push_back(v);
    end
  endfunction

  // ---- driver ----

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        absorb_pixel('{op: abs_pkg::op_t'(in_chan.operation), idx: in_chan.pixel_index,
                       px: {in_chan.chan2, in_chan.chan1, in_chan.chan0},
                       eof: in_chan.end_of_frame});
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_pixels.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
          pixel_txn_t t;
          t = pending_pixels.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.operation    <= t.op;
          in_chan.pixel_index  <= t.idx;
          in_chan.chan0        <= t.px[0];
          in_chan.chan1        <= t.px[1];
          in_chan.chan2        <= t.px[2];
          in_chan.end_of_frame <= t.eof;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= no_idle || ($urandom_range(99) >= 37);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d", out_chan.out_index));
        end else begin
          verdict_t v;
          v = expected_verdicts.pop_front();
          if (out_chan.out_index !== v.idx)
            report_mismatch($sformatf("out_index %0d, want %0d", out_chan.out_index, v.idx));
          if (out_chan.foreground !== v.fg)
            report_mismatch($sformatf("foreground %0b, want %0b at index %0d",
                                      out_chan.foreground, v.fg, v.idx));
        end
      end
    end
  end

  // ---- stimulus ----

  // pixel positions in use; first and last cover every index bit
  int unsigned spots[10] = '{0, 1, 2, 3, 4, 5, 6, 7, 1234, 65535};
  // generator's own view, so no pixel is learned after the first frame unless seen in it
  bit          gen_first;
  int unsigned gen_frames;
  chan_pix_t   gen_last [int];

  task automatic queue_pixel(abs_pkg::op_t op, int unsigned idx, chan_pix_t px, bit eof);
    pixel_txn_t t;
    t.op = op;
    t.idx = idx;
    t.px = px;
    t.eof = eof;
    if (op == abs_pkg::OP_LEARN && gen_frames < abs_pkg::MAX_FRAMES) begin
      if (gen_first) gen_last[idx] = px;
      else if (gen_last.exists(idx)) gen_last[idx] = px;
      else return;  // would read an unwritten previous value
      if (eof) begin
        if (!gen_first) gen_frames++;
        gen_first = 0;
      end
    end
    pending_pixels.push_back(t);
  endtask

  function automatic chan_pix_t near_px(chan_pix_t base, int spread);
    chan_pix_t r;
    int v;
    for (int c = 0; c < 3; c++) begin
      v = int'(base[c]) + $urandom_range(2 * spread) - spread;
      r[c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    end
    return r;
  endfunction

  task automatic random_pixels(int count);
    int unsigned idx, k;
    chan_pix_t px;
    for (int i = 0; i < count; i++) begin
      idx = spots[$urandom_range(9)];
      px = {8'($urandom), 8'($urandom), 8'($urandom)};
      k = $urandom_range(99);
      if (k < 40) begin
        // a short frame: one to three learn pixels, eof on the last
        int len;
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) begin
          idx = spots[$urandom_range(9)];
          px = gen_last.exists(idx) ? near_px(gen_last[idx], 12) : px;
          queue_pixel(abs_pkg::OP_LEARN, idx, px, j == len - 1);
        end
      end else if (k < 85) begin
        // classify close to the learned value, sometimes far off
        if (gen_last.exists(idx) && $urandom_range(3) != 0)
          px = near_px(gen_last[idx], $urandom_range(1, 60));
        queue_pixel(abs_pkg::OP_CLASSIFY, idx, px, $urandom_range(1));
      end else begin
        // noise: stray learn without frame end, or fully random classify
        queue_pixel(abs_pkg::op_t'($urandom_range(1)), idx, px, 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || in_chan.valid || expected_verdicts.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [abs_pkg::CFG_IDX_W-1:0] idx,
                           logic [abs_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == abs_pkg::CFG_HIGH_SCALE) upper_mult = val;
    else lower_mult = val;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.operation = 1'b0;
    in_chan.pixel_index = '0;
    in_chan.chan0 = '0;
    in_chan.chan1 = '0;
    in_chan.chan2 = '0;
    in_chan.end_of_frame = 1'b0;
    out_chan.ready = 1'b0;
    error_count = 0;
    no_idle = 0;
    frames_seen = 0;
    in_first_frame = 1;
    upper_mult = abs_pkg::HIGH_SCALE_RST;
    lower_mult = abs_pkg::LOW_SCALE_RST;
    gen_first = 1;
    gen_frames = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero count: background only when every channel is at most high_scale
    queue_pixel(abs_pkg::OP_CLASSIFY, 0, '0, 1'b0);
    queue_pixel(abs_pkg::OP_CLASSIFY, 65535, {8'd20, 8'd20, 8'd20}, 1'b1);
    queue_pixel(abs_pkg::OP_CLASSIFY, 1, {8'd20, 8'd21, 8'd0}, 1'b0);
    queue_pixel(abs_pkg::OP_CLASSIFY, 2, {8'd255, 8'd255, 8'd255}, 1'b0);
    // first frame only stores previous values
    foreach (spots[i])
      queue_pixel(abs_pkg::OP_LEARN, spots[i], (i % 2) ? {8'd255, 8'd255, 8'd255} : '0,
                  i == 9);
    // still zero count during the second frame although sums grow
    queue_pixel(abs_pkg::OP_LEARN, 0, {8'd255, 8'd0, 8'd255}, 1'b0);
    queue_pixel(abs_pkg::OP_CLASSIFY, 0, {8'd20, 8'd0, 8'd20}, 1'b0);
    queue_pixel(abs_pkg::OP_LEARN, 65535, '0, 1'b1);
    queue_pixel(abs_pkg::OP_CLASSIFY, 0, {8'd255, 8'd0, 8'd255}, 1'b0);
    queue_pixel(abs_pkg::OP_CLASSIFY, 65535, '0, 1'b0);
    queue_pixel(abs_pkg::OP_CLASSIFY, 65535, {8'd255, 8'd255, 8'd255}, 1'b0);
    // sender holds until every result is back
    wait_drained();

    // phase with no idling on either side, reset scales
    no_idle = 1;
    random_pixels(60);
    wait_drained();
    no_idle = 0;

    write_reg(abs_pkg::CFG_HIGH_SCALE, 8'd0);
    write_reg(abs_pkg::CFG_LOW_SCALE, 8'd0);
    random_pixels(60);
    wait_drained();

    write_reg(abs_pkg::CFG_HIGH_SCALE, 8'd255);
    write_reg(abs_pkg::CFG_LOW_SCALE, 8'd255);
    random_pixels(60);
    wait_drained();

    write_reg(abs_pkg::CFG_HIGH_SCALE, 8'($urandom));
    write_reg(abs_pkg::CFG_LOW_SCALE, 8'($urandom));
    random_pixels(60);
    wait_drained();

    // finish learning with whole-frame learns, then keep classifying after it stops
    write_reg(abs_pkg::CFG_HIGH_SCALE, 8'd1);
    write_reg(abs_pkg::CFG_LOW_SCALE, 8'd200);
    for (int i = 0; i < 300 && gen_frames < abs_pkg::MAX_FRAMES; i++)
      queue_pixel(abs_pkg::OP_LEARN, spots[$urandom_range(9)], {8'($urandom), 8'($urandom),
                  8'($urandom)}, 1'b1);
    random_pixels(60);
    wait_drained();
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog; covers the clearing pass after reset with a wide margin
  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ===== average_background_subtractor_core.f =====
sv/abs_pkg.sv
sv/abs_in_if.sv
sv/abs_out_if.sv
sv/abs_front.sv
sv/abs_queue.sv
sv/abs_back.sv
sv/average_background_subtractor_core.sv
test/tb.sv
